>>> src/dqfe_pkg.sv
// Shared types and codes for the double-ended queue with filter and extremes.
// No dependencies; imported by deque_with_filter_and_extremes.
`default_nettype none

package dqfe_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_DELETE     = 3'd2,
        ACT_READ_FWD   = 3'd3,
        ACT_READ_REV   = 3'd4,
        ACT_EXTREMES   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

endpackage

`default_nettype wire

>>> src/deque_with_filter_and_extremes.sv
// Top level: bounded double-ended queue over a ring store in one synchronous RAM.
// Depends on dqfe_pkg (action, status and state codes).
`default_nettype none

// Usage and timing
// ----------------
// A command transfers at a rising edge where start is high and busy is low.
// Each result is on the o_ ports for exactly one cycle, flagged by o_valid;
// there is no way to hold it off, so the receiver must take it as it comes.
// Every command except the unused codes six and seven yields at least one
// result, and the final result of a command carries o_last_of_run.
// Command flow:
//   - Push front/back, and delete/read/extremes on an empty queue: the result
//     appears the cycle after the transfer and busy stays low, so a new command
//     may follow at once.
//   - Delete, read forward, read reverse and extremes on N live entries:
//     busy after the transfer until the walk ends. The entry store is one RAM
//     with one registered read port, and these commands walk it one entry per
//     cycle; that walk sets how long busy stays high. Reads deliver one entry
//     per cycle, the first once the RAM read register and the result register
//     have both been loaded.
// Delete compacts in place: the write pointer (entries kept) never passes
// the read pointer, so read and write-back never touch the same live entry.
// The store has no reset or clearing pass; only live entries are ever read.
module deque_with_filter_and_extremes #(
    parameter int CAPACITY = 32
) (
    input  wire                logic        i_clk,
    input  wire                logic        i_rst_n,
    input  wire                logic        start,
    output                     logic        busy,
    input  wire                logic [2:0]  i_action,
    input  wire                logic signed [31:0] i_score,
    output                     logic        o_valid,
    output                     logic [1:0]  o_status,
    output                     logic signed [31:0] o_item_value,
    output                     logic signed [31:0] o_lowest_value,
    output                     logic        o_last_of_run
);
    import dqfe_pkg::*;

    localparam int AW = $clog2(CAPACITY);       // ring index width
    localparam int CW = $clog2(CAPACITY + 1);   // entry count width
    localparam logic [AW:0]   CAP_S  = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_I = AW'(CAPACITY - 1);

    // ring position of (front + offset)
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, f} + {1'b0, off};
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[AW-1:0];
    endfunction

    // entry store
    logic        [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_mem_q;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [31:0]        wr_data;

    // control and walk state
    t_state             r_state, n_state;
    t_action            r_op, n_op;
    logic [AW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;       // reads issued
    logic [CW-1:0]      r_pidx, n_pidx;     // read data consumed
    logic [CW-1:0]      r_kept, n_kept;     // delete: entries kept so far
    logic               r_rdv, n_rdv;       // r_mem_q holds fresh data
    logic signed [31:0] r_score, n_score;
    logic signed [31:0] r_hi, n_hi, r_lo, n_lo;

    // result register
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic signed [31:0] r_item, n_item, r_low, n_low;
    logic               r_last, n_last;

    logic               full, empty, last_item;
    logic [CW-1:0]      kept_nx, rev_off;
    logic signed [31:0] hi_nx, lo_nx;

    assign full      = (r_count == CAP_C);
    assign empty     = (r_count == '0);
    assign last_item = ((r_pidx + CW'(1)) == r_count);
    assign rev_off   = r_count - CW'(1) - r_idx;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_kept   = r_kept;
        n_rdv    = 1'b0;
        n_score  = r_score;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_item   = '0;
        n_low    = '0;
        n_last   = 1'b1;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = i_score;
        kept_nx  = r_kept;
        hi_nx    = r_hi;
        lo_nx    = r_lo;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_action'(i_action);
                    n_score = i_score;
                    case (t_action'(i_action)) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (t_action'(i_action) == ACT_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? LAST_I
                                                              : r_front - AW'(1);
                                    wr_addr = n_front;
                                end else begin
                                    wr_addr = slot(r_front, r_count[AW-1:0]);
                                end
                            end
                        end
                        ACT_DELETE, ACT_READ_FWD, ACT_READ_REV, ACT_EXTREMES: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                                n_idx   = '0;
                                n_pidx  = '0;
                                n_kept  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // issue side: one RAM read per cycle
                if (r_idx != r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_front, (r_op == ACT_READ_REV) ? rev_off[AW-1:0]
                                                                   : r_idx[AW-1:0]);
                    n_idx   = r_idx + CW'(1);
                    n_rdv   = 1'b1;
                end
                // consume side: data of the previous read
                if (r_rdv) begin
                    n_pidx = r_pidx + CW'(1);
                    case (r_op) inside
                        ACT_READ_FWD, ACT_READ_REV: begin
                            n_valid = 1'b1;
                            n_item  = r_mem_q;
                            n_last  = last_item;
                            if (last_item) begin
                                n_state = S_IDLE;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_mem_q != r_score) begin
                                wr_en   = 1'b1;
                                wr_addr = slot(r_front, r_kept[AW-1:0]);
                                wr_data = r_mem_q;
                                kept_nx = r_kept + CW'(1);
                            end
                            n_kept = kept_nx;
                            if (last_item) begin
                                n_valid  = 1'b1;
                                n_status = (kept_nx == r_count) ? ST_NOT_FOUND : ST_OK;
                                n_count  = kept_nx;
                                n_state  = S_IDLE;
                            end
                        end
                        ACT_EXTREMES: begin
                            hi_nx = (r_pidx == '0 || r_mem_q > r_hi) ? r_mem_q : r_hi;
                            lo_nx = (r_pidx == '0 || r_mem_q < r_lo) ? r_mem_q : r_lo;
                            n_hi  = hi_nx;
                            n_lo  = lo_nx;
                            if (last_item) begin
                                n_valid = 1'b1;
                                n_item  = hi_nx;
                                n_low   = lo_nx;
                                n_state = S_IDLE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_rdv   <= 1'b0;
            r_valid <= 1'b0;
            r_op    <= ACT_PUSH_FRONT;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_rdv   <= n_rdv;
            r_valid <= n_valid;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_kept   <= n_kept;
        r_score  <= n_score;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_status <= n_status;
        r_item   <= n_item;
        r_low    <= n_low;
        r_last   <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_item_value   = r_item;
    assign o_lowest_value = r_low;
    assign o_last_of_run  = r_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !full &&
         (i_action == ACT_PUSH_FRONT || i_action == ACT_PUSH_BACK))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the queue");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last_of_run)
        else $error("error status on a non-final result");

    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_op == ACT_EXTREMES && o_status == ST_OK)
        |-> (o_item_value >= o_lowest_value))
        else $error("highest value below lowest value");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_pidx <= r_idx && r_kept <= r_pidx))
        else $error("walk pointers out of order");

endmodule

`default_nettype wire

>>> sim/deque_with_filter_and_extremes_tb.sv
// Self-checking testbench for deque_with_filter_and_extremes: directed and random commands,
// every result checked against a behavioral deque kept inside the bench.
// Depends on dqfe_pkg and the deque_with_filter_and_extremes RTL.
`timescale 1ns / 100ps

module deque_with_filter_and_extremes_tb;

    import dqfe_pkg::*;

    localparam int CAPACITY        = 32;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int MAX_GAP         = 36;   // longest sender gap, spans a whole full-store walk
    localparam int WATCHDOG_CYCLES = 400;  // quiet cycles (no transfer, no result) before abort
    localparam int MAX_PRINTED     = 100;  // keep a badly broken DUT from flooding the log

    // Action codes the block ignores (no result, queue left unchanged).
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    typedef struct {
        t_status            status;
        logic signed [31:0] item_value;
        logic signed [31:0] lowest_value;
        logic               last_of_run;
    } t_deque_result;

    // DUT ports; the inputs are all known from time zero.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    logic [2:0]         i_action = ACT_PUSH_FRONT;
    logic signed [31:0] i_score  = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_item_value;
    logic signed [31:0] o_lowest_value;
    logic               o_last_of_run;

    // Bench copy of the deque.
    logic signed [31:0] dq_store [CAPACITY];
    int unsigned        dq_front = 0;
    int unsigned        dq_count = 0;

    t_deque_result      due_results [$];   // results owed by the DUT, oldest first
    logic signed [31:0] pushed_vals [$];   // recent push values, reused as delete targets
    int                 gap_pct     = 0;   // chance in 100 of a sender gap before a command
    int                 mismatches  = 0;
    int                 quiet_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    deque_with_filter_and_extremes #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_score        (i_score),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_item_value   (o_item_value),
        .o_lowest_value (o_lowest_value),
        .o_last_of_run  (o_last_of_run)
    );

    // ------------------------------------------------------------------
    // Behavioral deque
    // ------------------------------------------------------------------

    function automatic int unsigned ring_pos(int unsigned offset);
        return (dq_front + offset) % CAPACITY;
    endfunction

    function automatic void owe(t_status st, logic signed [31:0] item,
                                logic signed [31:0] low, logic last);
        t_deque_result r;
        r.status       = st;
        r.item_value   = item;
        r.lowest_value = low;
        r.last_of_run  = last;
        due_results.push_back(r);
    endfunction

    // Applies one accepted command to the bench deque and queues what it must produce.
    function automatic void deque_apply(logic [2:0] act, logic signed [31:0] val);
        int unsigned        kept;
        int unsigned        pos;
        logic signed [31:0] v;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (dq_count >= CAPACITY) begin
                    owe(ST_FULL, '0, '0, 1'b1);
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        dq_front = (dq_front + CAPACITY - 1) % CAPACITY;
                        dq_store[dq_front] = val;
                    end else begin
                        dq_store[ring_pos(dq_count)] = val;
                    end
                    dq_count++;
                    owe(ST_OK, '0, '0, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (dq_count == 0) begin
                    owe(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    // in-place compaction: survivors slide toward the front
                    kept = 0;
                    for (int unsigned i = 0; i < dq_count; i++) begin
                        v = dq_store[ring_pos(i)];
                        if (v != val) begin
                            dq_store[ring_pos(kept)] = v;
                            kept++;
                        end
                    end
                    if (kept == dq_count) begin
                        owe(ST_NOT_FOUND, '0, '0, 1'b1);
                    end else begin
                        dq_count = kept;
                        owe(ST_OK, '0, '0, 1'b1);
                    end
                end
            end
            ACT_READ_FWD, ACT_READ_REV: begin
                if (dq_count == 0) begin
                    owe(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < dq_count; i++) begin
                        pos = (act == ACT_READ_FWD) ? i : dq_count - 1 - i;
                        owe(ST_OK, dq_store[ring_pos(pos)], '0, (i + 1 == dq_count));
                    end
                end
            end
            ACT_EXTREMES: begin
                if (dq_count == 0) begin
                    owe(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    hi = dq_store[ring_pos(0)];
                    lo = hi;
                    for (int unsigned i = 1; i < dq_count; i++) begin
                        v = dq_store[ring_pos(i)];
                        if (v > hi) hi = v;
                        if (v < lo) lo = v;
                    end
                    owe(ST_OK, hi, lo, 1'b1);
                end
            end
            default: ;  // spare codes: nothing happens
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking and watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                   input logic signed [31:0] got);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Everything is sampled at the rising edge, so values seen are the ones before it.
    // The result strobe is checked before a new command is modeled: a command's first
    // result can never land on its own transfer edge, so the order is safe.
    always @(posedge i_clk) begin
        t_deque_result want;
        logic          moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            dq_front     = 0;
            dq_count     = 0;
            quiet_cycles = 0;
        end else begin
            if (o_valid) begin
                moved = 1'b1;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result, item_value", '0, o_item_value);
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(o_status));
                    if (o_item_value !== want.item_value)
                        report_mismatch("item_value", want.item_value, o_item_value);
                    if (o_lowest_value !== want.lowest_value)
                        report_mismatch("lowest_value", want.lowest_value, o_lowest_value);
                    if (o_last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(want.last_of_run),
                                        32'(o_last_of_run));
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                deque_apply(i_action, i_score);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Holds one command on the ports until it transfers. Called right after a rising
    // edge; start is only ever assigned once per edge.
    task automatic send_cmd(input logic [2:0] act, input logic signed [31:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_score  <= val;
        if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
            pushed_vals.push_back(val);
            if (pushed_vals.size() > 24) void'(pushed_vals.pop_front());
        end
        do @(posedge i_clk); while (busy);
    endtask

    // Sender idle; junk on the payload ports while start is low.
    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            start    <= 1'b0;
            i_action <= 3'($urandom());
            i_score  <= $urandom();
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic maybe_gap();
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            sender_gap($urandom_range(1, MAX_GAP));
    endtask

    // Sender holds off until every owed result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Value mix: repeats and extremes make deletes hit and several copies go at once.
    function automatic logic signed [31:0] pick_value(input bit for_delete);
        int r;
        r = $urandom_range(99);
        if (for_delete && r < 60 && pushed_vals.size() != 0)
            return pushed_vals[$urandom_range(pushed_vals.size() - 1)];
        if (r < 80 && r >= 60 - (for_delete ? 0 : 30))
            return $signed($urandom_range(4)) - 2;
        if (r < 90)
            return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-queue statuses, spare codes, extreme values, multi-match delete,
    // delete with no match, both read directions, single-entry extremes.
    task automatic test_directed();
        send_cmd(ACT_READ_FWD, '0);
        send_cmd(ACT_READ_REV, '0);
        send_cmd(ACT_EXTREMES, '0);
        send_cmd(ACT_DELETE, 32'sd9);
        send_cmd(ACT_RSVD6, 32'sh5a5a5a5a);
        send_cmd(ACT_RSVD7, -32'sd1);
        send_cmd(ACT_PUSH_BACK, 32'sh7fffffff);
        send_cmd(ACT_PUSH_FRONT, 32'sh80000000);
        send_cmd(ACT_PUSH_BACK, 32'sd0);
        send_cmd(ACT_PUSH_FRONT, -32'sd1);
        send_cmd(ACT_PUSH_BACK, 32'sd5);
        send_cmd(ACT_PUSH_FRONT, 32'sd5);
        send_cmd(ACT_READ_FWD, '0);
        send_cmd(ACT_READ_REV, '0);
        send_cmd(ACT_EXTREMES, '0);
        send_cmd(ACT_DELETE, 32'sd5);          // two copies, one at each end
        send_cmd(ACT_DELETE, 32'sd12345);      // not there
        send_cmd(ACT_DELETE, 32'sh80000000);
        send_cmd(ACT_READ_FWD, '0);
        send_cmd(ACT_DELETE, -32'sd1);
        send_cmd(ACT_DELETE, 32'sh7fffffff);
        send_cmd(ACT_DELETE, 32'sd0);          // queue goes empty
        send_cmd(ACT_EXTREMES, '0);
        send_cmd(ACT_PUSH_FRONT, 32'sd42);
        send_cmd(ACT_EXTREMES, '0);            // highest equals lowest
        send_cmd(ACT_READ_REV, '0);
        wait_drained();
    endtask

    // Fill past capacity from both ends, then walk and thin the full store.
    task automatic test_full_store();
        for (int i = 0; i < 36; i++)
            send_cmd($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value(1'b0));
        send_cmd(ACT_READ_FWD, '0);
        send_cmd(ACT_READ_REV, '0);
        send_cmd(ACT_EXTREMES, '0);
        send_cmd(ACT_DELETE, pick_value(1'b1));
        send_cmd(ACT_PUSH_BACK, $urandom());
        send_cmd(ACT_PUSH_FRONT, $urandom());
        send_cmd(ACT_READ_FWD, '0);
        wait_drained();
    endtask

    // Weighted random commands; pushes outweigh deletes so the store fills and
    // drains in waves, with reads and extremes over every fill level.
    task automatic test_random(input int count, input int pct);
        int r;
        gap_pct = pct;
        for (int n = 0; n < count; n++) begin
            maybe_gap();
            r = $urandom_range(99);
            if (r < 40)
                send_cmd($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value(1'b0));
            else if (r < 65)
                send_cmd(ACT_DELETE, pick_value(1'b1));
            else if (r < 75)
                send_cmd(ACT_READ_FWD, $urandom());
            else if (r < 85)
                send_cmd(ACT_READ_REV, $urandom());
            else if (r < 97)
                send_cmd(ACT_EXTREMES, $urandom());
            else
                send_cmd($urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7, $urandom());
        end
        gap_pct = 0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random(70, 0);
        wait_drained();
        test_random(70, 61);
        wait_drained();
        test_random(70, 23);
        test_random(60, 0);

        // drain, then give a full-store walk of margin for anything stray
        wait_drained();
        repeat (CAPACITY + 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
